[hw/rtl/m6502_pkg.sv]
// Shared types and operation codes for the 6502 execute unit.
package m6502_pkg;

    localparam logic [5:0] OP_ORA = 6'd0;
    localparam logic [5:0] OP_AND = 6'd1;
    localparam logic [5:0] OP_EOR = 6'd2;
    localparam logic [5:0] OP_ADC = 6'd3;
    localparam logic [5:0] OP_SBC = 6'd4;
    localparam logic [5:0] OP_CMP = 6'd5;
    localparam logic [5:0] OP_CPX = 6'd6;
    localparam logic [5:0] OP_CPY = 6'd7;
    localparam logic [5:0] OP_BIT = 6'd8;
    localparam logic [5:0] OP_LDA = 6'd9;
    localparam logic [5:0] OP_LDX = 6'd10;
    localparam logic [5:0] OP_LDY = 6'd11;
    localparam logic [5:0] OP_STA = 6'd12;
    localparam logic [5:0] OP_STX = 6'd13;
    localparam logic [5:0] OP_STY = 6'd14;
    localparam logic [5:0] OP_ASL = 6'd15;
    localparam logic [5:0] OP_LSR = 6'd16;
    localparam logic [5:0] OP_ROL = 6'd17;
    localparam logic [5:0] OP_ROR = 6'd18;
    localparam logic [5:0] OP_INC = 6'd19;
    localparam logic [5:0] OP_DEC = 6'd20;
    localparam logic [5:0] OP_INY = 6'd21;
    localparam logic [5:0] OP_DEY = 6'd22;
    localparam logic [5:0] OP_TAX = 6'd23;
    localparam logic [5:0] OP_PHA = 6'd24;
    localparam logic [5:0] OP_PLA = 6'd25;
    localparam logic [5:0] OP_CLC = 6'd26;
    localparam logic [5:0] OP_CLD = 6'd27;
    localparam logic [5:0] OP_CLI = 6'd28;
    localparam logic [5:0] OP_CLV = 6'd29;
    localparam logic [5:0] OP_BNE = 6'd30;
    localparam logic [5:0] OP_BEQ = 6'd31;
    localparam logic [5:0] OP_BPL = 6'd32;
    localparam logic [5:0] OP_BMI = 6'd33;
    localparam logic [5:0] OP_BCC = 6'd34;

    localparam logic [7:0] SP_RESET    = 8'hFF;
    localparam logic [7:0] FLAGS_RESET = 8'h20;
    localparam logic       STACK_PAGE  = 1'b1;

    typedef struct packed {
        logic [5:0] func;
        logic       on_acc;
        logic [7:0] operand;
        logic       valid_op;
    } t_op;

    typedef struct packed {
        logic [7:0] write_data;
        logic       mem_write;
        logic       stack_access;
        logic [8:0] stack_address;
        logic       branch_taken;
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] flags;
    } t_res;

endpackage

[hw/rtl/m6502_front.sv]
// Front end: accepts operations, classifies them and feeds a two-entry queue.
module m6502_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [5:0]       i_func,
    input  logic             i_on_accumulator,
    input  logic [7:0]       i_operand,
    output logic             o_q_valid,
    output m6502_pkg::t_op   o_q_op,
    input  logic             i_q_pop
);
    import m6502_pkg::*;

    t_op        r_ent [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       push;
    logic       pop;
    t_op        new_op;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_op    = r_ent[r_rd];

    always_comb begin
        new_op.func     = i_func;
        new_op.on_acc   = i_on_accumulator;
        new_op.operand  = i_operand;
        new_op.valid_op = (i_func <= OP_BCC);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr] <= new_op;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[hw/rtl/m6502_back.sv]
// Back end: executes one operation per cycle on the register file while the output is not stalled.
module m6502_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  m6502_pkg::t_op  i_q_op,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output m6502_pkg::t_res o_res
);
    import m6502_pkg::*;

    logic [7:0] r_a, r_x, r_y, r_sp, r_p;
    logic [7:0] n_a, n_x, n_y, n_sp, n_p;
    logic       r_valid;
    t_res       r_res;
    t_res       n_res;
    logic       fire;
    logic [7:0] v, r, m, addend;
    logic [8:0] sum;
    logic [8:0] diff;
    logic [7:0] cmp_reg;

    assign fire    = i_q_valid && (!r_valid || !i_stall);
    assign o_q_pop = fire;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        m       = i_q_op.operand;
        n_a     = r_a;
        n_x     = r_x;
        n_y     = r_y;
        n_sp    = r_sp;
        n_p     = r_p;
        n_res   = '0;
        v       = i_q_op.on_acc ? r_a : m;
        r       = v;
        addend  = (i_q_op.func == OP_SBC) ? ~m : m;
        sum     = {1'b0, r_a} + {1'b0, addend} + {8'd0, r_p[0]};
        cmp_reg = (i_q_op.func == OP_CPX) ? r_x : ((i_q_op.func == OP_CPY) ? r_y : r_a);
        diff    = {1'b0, cmp_reg} - {1'b0, m};
        if (i_q_op.valid_op) begin
            unique case (i_q_op.func)
                OP_ORA: begin n_a = r_a | m; n_p[1] = (n_a == 8'd0); n_p[7] = n_a[7]; end
                OP_AND: begin n_a = r_a & m; n_p[1] = (n_a == 8'd0); n_p[7] = n_a[7]; end
                OP_EOR: begin n_a = r_a ^ m; n_p[1] = (n_a == 8'd0); n_p[7] = n_a[7]; end
                OP_ADC, OP_SBC: begin
                    n_a    = sum[7:0];
                    n_p[0] = sum[8];
                    n_p[6] = ~(r_a[7] ^ addend[7]) & (r_a[7] ^ sum[7]);
                    n_p[1] = (n_a == 8'd0);
                    n_p[7] = n_a[7];
                end
                OP_CMP, OP_CPX, OP_CPY: begin
                    n_p[0] = ~diff[8];
                    n_p[1] = (diff[7:0] == 8'd0);
                    n_p[7] = diff[7];
                end
                OP_BIT: begin
                    n_p[1] = ((r_a & m) == 8'd0);
                    n_p[6] = m[6];
                    n_p[7] = m[7];
                end
                OP_LDA: begin n_a = m; n_p[1] = (m == 8'd0); n_p[7] = m[7]; end
                OP_LDX: begin n_x = m; n_p[1] = (m == 8'd0); n_p[7] = m[7]; end
                OP_LDY: begin n_y = m; n_p[1] = (m == 8'd0); n_p[7] = m[7]; end
                OP_STA: begin n_res.write_data = r_a; n_res.mem_write = 1'b1; end
                OP_STX: begin n_res.write_data = r_x; n_res.mem_write = 1'b1; end
                OP_STY: begin n_res.write_data = r_y; n_res.mem_write = 1'b1; end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
                    unique case (i_q_op.func)
                        OP_ASL:  begin n_p[0] = v[7]; r = {v[6:0], 1'b0}; end
                        OP_LSR:  begin n_p[0] = v[0]; r = {1'b0, v[7:1]}; end
                        OP_ROL:  begin n_p[0] = v[7]; r = {v[6:0], r_p[0]}; end
                        OP_ROR:  begin n_p[0] = v[0]; r = {r_p[0], v[7:1]}; end
                        OP_INC:  r = v + 8'd1;
                        default: r = v - 8'd1;
                    endcase
                    n_p[1] = (r == 8'd0);
                    n_p[7] = r[7];
                    if (i_q_op.on_acc) begin
                        n_a = r;
                    end else begin
                        n_res.write_data = r;
                        n_res.mem_write  = 1'b1;
                    end
                end
                OP_INY: begin n_y = r_y + 8'd1; n_p[1] = (n_y == 8'd0); n_p[7] = n_y[7]; end
                OP_DEY: begin n_y = r_y - 8'd1; n_p[1] = (n_y == 8'd0); n_p[7] = n_y[7]; end
                OP_TAX: begin n_x = r_a; n_p[1] = (r_a == 8'd0); n_p[7] = r_a[7]; end
                OP_PHA: begin
                    n_res.write_data   = r_a;
                    n_res.mem_write    = 1'b1;
                    n_res.stack_access = 1'b1;
                    n_sp               = r_sp - 8'd1;
                end
                OP_PLA: begin
                    n_sp               = r_sp + 8'd1;
                    n_res.stack_access = 1'b1;
                    n_a                = m;
                    n_p[1]             = (m == 8'd0);
                    n_p[7]             = m[7];
                end
                OP_CLC: n_p[0] = 1'b0;
                OP_CLD: n_p[3] = 1'b0;
                OP_CLI: n_p[2] = 1'b0;
                OP_CLV: n_p[6] = 1'b0;
                OP_BNE: n_res.branch_taken = ~r_p[1];
                OP_BEQ: n_res.branch_taken = r_p[1];
                OP_BPL: n_res.branch_taken = ~r_p[7];
                OP_BMI: n_res.branch_taken = r_p[7];
                OP_BCC: n_res.branch_taken = ~r_p[0];
                default: ;
            endcase
        end
        n_res.stack_address = (i_q_op.func == OP_PHA && i_q_op.valid_op) ?
                              {STACK_PAGE, r_sp} : {STACK_PAGE, n_sp};
        n_res.acc   = n_a;
        n_res.x     = n_x;
        n_res.y     = n_y;
        n_res.flags = n_p;
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
        if (!i_rst_n) begin
            r_a     <= 8'd0;
            r_x     <= 8'd0;
            r_y     <= 8'd0;
            r_sp    <= SP_RESET;
            r_p     <= FLAGS_RESET;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_a  <= n_a;
                r_x  <= n_x;
                r_y  <= n_y;
                r_sp <= n_sp;
                r_p  <= n_p;
            end
            if (fire) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end
endmodule

[hw/rtl/mos6502_execute_unit.sv]
// Top level of the 6502 execute unit: front queue plus execute back end.
// Each operation is executed by a combinational ALU and an output register stage, so a new
// transaction can be accepted every cycle while the output is not stalled; an accepted
// transaction passes through the two-entry queue and then the output register.
// A stall on the output holds the result while up to two more transactions are queued.
module mos6502_execute_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [5:0] i_func,
    input  logic       i_on_accumulator,
    input  logic [7:0] i_operand,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_write_data,
    output logic       o_mem_write,
    output logic       o_stack_access,
    output logic [8:0] o_stack_address,
    output logic       o_branch_taken,
    output logic [7:0] o_acc_value,
    output logic [7:0] o_x_value,
    output logic [7:0] o_y_value,
    output logic [7:0] o_flags_value
);
    import m6502_pkg::*;

    logic q_valid;
    logic q_pop;
    t_op  q_op;
    t_res res;

    m6502_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_on_accumulator (i_on_accumulator),
        .i_operand        (i_operand),
        .o_q_valid        (q_valid),
        .o_q_op           (q_op),
        .i_q_pop          (q_pop)
    );

    m6502_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_op    (q_op),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (res)
    );

    assign o_write_data    = res.write_data;
    assign o_mem_write     = res.mem_write;
    assign o_stack_access  = res.stack_access;
    assign o_stack_address = res.stack_address;
    assign o_branch_taken  = res.branch_taken;
    assign o_acc_value     = res.acc;
    assign o_x_value       = res.x;
    assign o_y_value       = res.y;
    assign o_flags_value   = res.flags;

`ifndef SYNTH
    a_stack_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stack_address[8]) else $error("stack address off page");
    a_flag_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_flags_value[5] && !o_flags_value[4]))
        else $error("reserved status bits changed");
    a_stack_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stack_access && !o_mem_write) |-> (o_write_data == 8'd0))
        else $error("pull drives write data");
`endif
endmodule

[test/testbench.sv]
// Self-checking testbench for the 6502 execute unit with a register-level predictor.
`timescale 1ns / 100ps

module testbench;
    import m6502_pkg::*;

    localparam logic [7:0] FL_C = 8'h01;
    localparam logic [7:0] FL_Z = 8'h02;
    localparam logic [7:0] FL_I = 8'h04;
    localparam logic [7:0] FL_D = 8'h08;
    localparam logic [7:0] FL_V = 8'h40;
    localparam logic [7:0] FL_N = 8'h80;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [5:0] i_func = '0;
    logic       i_on_accumulator = 1'b0;
    logic [7:0] i_operand = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_write_data;
    logic       o_mem_write;
    logic       o_stack_access;
    logic [8:0] o_stack_address;
    logic       o_branch_taken;
    logic [7:0] o_acc_value;
    logic [7:0] o_x_value;
    logic [7:0] o_y_value;
    logic [7:0] o_flags_value;

    mos6502_execute_unit i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    t_res       expected_results[$];
    int         error_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    function automatic void set_flag(input logic [7:0] mask, input logic on);
        cpu_p = on ? (cpu_p | mask) : (cpu_p & ~mask);
    endfunction

    function automatic void set_nz(input logic [7:0] v);
        set_flag(FL_Z, v == 8'h00);
        set_flag(FL_N, v[7]);
    endfunction

    function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] m);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, a} + {1'b0, m} + {8'h00, cpu_p[0]};
        r = sum[7:0];
        set_flag(FL_C, sum[8]);
        set_flag(FL_V, ~(a[7] ^ m[7]) & (a[7] ^ r[7]));
        set_nz(r);
        return r;
    endfunction

    function automatic void compare(input logic [7:0] reg_v, input logic [7:0] m);
        set_flag(FL_C, reg_v >= m);
        set_nz(reg_v - m);
    endfunction

    function automatic t_res execute_op(input logic [5:0] f, input logic on_acc,
                                        input logic [7:0] m);
        t_res       res;
        logic [7:0] v, r;
        logic       c;
        res = '0;
        c = cpu_p[0];
        if (f >= OP_ASL && f <= OP_DEC) begin
            v = on_acc ? cpu_a : m;
            case (f)
                OP_ASL: begin set_flag(FL_C, v[7]); r = v << 1; end
                OP_LSR: begin set_flag(FL_C, v[0]); r = v >> 1; end
                OP_ROL: begin set_flag(FL_C, v[7]); r = {v[6:0], c}; end
                OP_ROR: begin set_flag(FL_C, v[0]); r = {c, v[7:1]}; end
                OP_INC: r = v + 8'd1;
                default: r = v - 8'd1;
            endcase
            set_nz(r);
            if (on_acc) cpu_a = r;
            else begin
                res.write_data = r;
                res.mem_write = 1'b1;
            end
        end else begin
            case (f)
                OP_ORA: begin cpu_a = cpu_a | m; set_nz(cpu_a); end
                OP_AND: begin cpu_a = cpu_a & m; set_nz(cpu_a); end
                OP_EOR: begin cpu_a = cpu_a ^ m; set_nz(cpu_a); end
                OP_ADC: cpu_a = add_carry(cpu_a, m);
                OP_SBC: cpu_a = add_carry(cpu_a, ~m);
                OP_CMP: compare(cpu_a, m);
                OP_CPX: compare(cpu_x, m);
                OP_CPY: compare(cpu_y, m);
                OP_BIT: begin
                    set_flag(FL_Z, (cpu_a & m) == 8'h00);
                    set_flag(FL_V, m[6]);
                    set_flag(FL_N, m[7]);
                end
                OP_LDA: begin cpu_a = m; set_nz(m); end
                OP_LDX: begin cpu_x = m; set_nz(m); end
                OP_LDY: begin cpu_y = m; set_nz(m); end
                OP_STA: begin res.write_data = cpu_a; res.mem_write = 1'b1; end
                OP_STX: begin res.write_data = cpu_x; res.mem_write = 1'b1; end
                OP_STY: begin res.write_data = cpu_y; res.mem_write = 1'b1; end
                OP_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
                OP_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
                OP_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
                OP_PHA: begin
                    res.write_data = cpu_a;
                    res.mem_write = 1'b1;
                    res.stack_access = 1'b1;
                    res.stack_address = {1'b1, cpu_sp};
                    cpu_sp = cpu_sp - 8'd1;
                end
                OP_PLA: begin
                    cpu_sp = cpu_sp + 8'd1;
                    res.stack_access = 1'b1;
                    res.stack_address = {1'b1, cpu_sp};
                    cpu_a = m;
                    set_nz(m);
                end
                OP_CLC: set_flag(FL_C, 1'b0);
                OP_CLD: set_flag(FL_D, 1'b0);
                OP_CLI: set_flag(FL_I, 1'b0);
                OP_CLV: set_flag(FL_V, 1'b0);
                OP_BNE: res.branch_taken = ~cpu_p[1];
                OP_BEQ: res.branch_taken = cpu_p[1];
                OP_BPL: res.branch_taken = ~cpu_p[7];
                OP_BMI: res.branch_taken = cpu_p[7];
                OP_BCC: res.branch_taken = ~cpu_p[0];
                default: ;
            endcase
        end
        if (!res.stack_access) res.stack_address = {1'b1, cpu_sp};
        res.acc = cpu_a;
        res.x = cpu_x;
        res.y = cpu_y;
        res.flags = cpu_p;
        return res;
    endfunction

    task automatic send_op(input logic [5:0] f, input logic on_acc, input logic [7:0] m);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_on_accumulator <= on_acc;
        i_operand <= m;
        expected_results.push_back(execute_op(f, on_acc, m));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_write_data !== want.write_data)
                    report_mismatch("write_data", o_write_data, want.write_data);
                if (o_mem_write !== want.mem_write)
                    report_mismatch("mem_write", o_mem_write, want.mem_write);
                if (o_stack_access !== want.stack_access)
                    report_mismatch("stack_access", o_stack_access, want.stack_access);
                if (o_stack_address !== want.stack_address)
                    report_mismatch("stack_address", o_stack_address, want.stack_address);
                if (o_branch_taken !== want.branch_taken)
                    report_mismatch("branch_taken", o_branch_taken, want.branch_taken);
                if (o_acc_value !== want.acc) report_mismatch("acc", o_acc_value, want.acc);
                if (o_x_value !== want.x) report_mismatch("x", o_x_value, want.x);
                if (o_y_value !== want.y) report_mismatch("y", o_y_value, want.y);
                if (o_flags_value !== want.flags)
                    report_mismatch("flags", o_flags_value, want.flags);
            end
        end
    end

    task automatic test_directed();
        send_op(OP_LDA, 1'b0, 8'h00);
        send_op(OP_ADC, 1'b1, 8'hFF);
        send_op(OP_LDA, 1'b0, 8'h7F);
        send_op(OP_ADC, 1'b0, 8'h01);
        send_op(OP_SBC, 1'b0, 8'hFF);
        send_op(OP_CMP, 1'b0, 8'h80);
        send_op(OP_BIT, 1'b0, 8'hC0);
        send_op(OP_PLA, 1'b0, 8'hFF);
        send_op(OP_PHA, 1'b1, 8'h00);
        send_op(OP_PHA, 1'b0, 8'h55);
        send_op(OP_ASL, 1'b1, 8'h00);
        send_op(OP_ROR, 1'b0, 8'h01);
        send_op(OP_ROL, 1'b0, 8'h80);
        send_op(OP_LSR, 1'b1, 8'hAA);
        send_op(OP_INC, 1'b0, 8'hFF);
        send_op(OP_DEC, 1'b0, 8'h00);
        send_op(OP_DEY, 1'b1, 8'h00);
        send_op(OP_TAX, 1'b0, 8'h00);
        send_op(6'd35, 1'b1, 8'hFF);
        send_op(6'd63, 1'b0, 8'h00);
        send_op(OP_BMI, 1'b0, 8'h00);
        send_op(OP_CLV, 1'b0, 8'h00);
        send_op(OP_CLD, 1'b0, 8'h00);
        send_op(OP_CLI, 1'b0, 8'h00);
        send_op(OP_BCC, 1'b0, 8'h00);
    endtask

    task automatic test_random(input int count);
        logic [5:0] f;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(19) == 0) f = 6'($urandom_range(63, 35));
            else f = 6'($urandom_range(34));
            send_op(f, 1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    task automatic test_backpressure();
        i_valid <= 1'b0;
        hold_cycles = 40;
        @(posedge i_clk);
        test_random(30);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    initial begin
        cpu_a = 8'h00;
        cpu_x = 8'h00;
        cpu_y = 8'h00;
        cpu_sp = SP_RESET;
        cpu_p = FLAGS_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 20;
        recv_idle_pct = 85;
        test_directed();
        test_random(500);
        send_idle_pct = 85;
        recv_idle_pct = 20;
        test_random(500);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        recv_idle_pct = 0;
        wait_drained();
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
